// ===== rtl/shmm_pkg.sv =====
// ----------------------------------------------------------------------------
// shmm_pkg
// Shared types and constants of the seed hit match merger.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package shmm_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPAN_LENGTH    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_ADVANCE = 8'd1;

    localparam logic [15:0] SPAN_LENGTH_RESET    = 16'd150;
    localparam logic [5:0]  FILTER_ADVANCE_RESET = 6'd12;

    typedef struct packed {
        logic [15:0] query_start;
        logic [31:0] ref_start;
        logic [31:0] ref_ident;
        logic        group_end;
    } in_word_t;

    typedef struct packed {
        logic [15:0] match_query_start;
        logic [16:0] match_query_end;
        logic [31:0] match_ref_start;
        logic [32:0] match_ref_end;
        logic [31:0] match_ref_ident;
        logic        overflow_seen;
        logic        last_of_run;
    } out_word_t;

    typedef struct packed {
        logic [15:0] query_start;
        logic [31:0] ref_start;
        logic [31:0] ref_ident;
        logic        group_end;
        logic [16:0] query_end;
        logic [32:0] ref_end;
    } cmd_t;

    typedef struct packed {
        logic [15:0] last_query_start;
        logic [31:0] last_ref_start;
        logic [15:0] query_start;
        logic [16:0] query_end;
        logic [31:0] ref_start;
        logic [32:0] ref_end;
    } entry_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_ARD,
        BK_ACHK,
        BK_ADD,
        BK_FSTART,
        BK_FRD,
        BK_FCHK,
        BK_GSTART,
        BK_GRD,
        BK_GCHK,
        BK_DONE
    } back_state_t;

endpackage

`default_nettype wire

// ===== rtl/shmm_ram.sv =====
// ----------------------------------------------------------------------------
// shmm_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module shmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/shmm_fifo.sv =====
// ----------------------------------------------------------------------------
// shmm_fifo
// Small register queue with push/full and pop/empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module shmm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rdata,
    output logic                  empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == (AW+1)'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/shmm_front.sv =====
// ----------------------------------------------------------------------------
// shmm_front
// Accepts hits, forms their match ends and queues them for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module shmm_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire shmm_pkg::in_word_t hit,
    input  wire logic [15:0]       span_length,
    input  wire logic              cmd_pop,
    output logic                   cmd_empty,
    output shmm_pkg::cmd_t         cmd
);

    shmm_pkg::cmd_t cmd_in;
    logic [$bits(shmm_pkg::cmd_t)-1:0] cmd_bits;

    always_comb
    begin
        cmd_in.query_start = hit.query_start;
        cmd_in.ref_start   = hit.ref_start;
        cmd_in.ref_ident   = hit.ref_ident;
        cmd_in.group_end   = hit.group_end;
        cmd_in.query_end   = 17'(hit.query_start) + 17'(span_length);
        cmd_in.ref_end     = 33'(hit.ref_start) + 33'(span_length);
    end

    shmm_fifo #(
        .WIDTH($bits(shmm_pkg::cmd_t)),
        .DEPTH(2)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cmd_in),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (cmd_bits),
        .empty (cmd_empty)
    );

    assign cmd = shmm_pkg::cmd_t'(cmd_bits);

endmodule

`default_nettype wire

// ===== rtl/shmm_back.sv =====
// ----------------------------------------------------------------------------
// shmm_back
// Walks the open match list for each hit: extend or open, filter, flush.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module shmm_back #(
    parameter int MAX_OPEN = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire shmm_pkg::cmd_t              cmd,
    input  wire logic                        cmd_empty,
    output logic                             cmd_pop,
    input  wire logic [5:0]                  filter_advance,
    output logic                             ram_we,
    output logic [$clog2(MAX_OPEN)-1:0]      ram_waddr,
    output shmm_pkg::entry_t                 ram_wdata,
    output logic [$clog2(MAX_OPEN)-1:0]      ram_raddr,
    input  wire shmm_pkg::entry_t            ram_rdata,
    output logic                             res_push,
    output shmm_pkg::out_word_t              res_word,
    input  wire logic                        res_full
);

    localparam int IW = $clog2(MAX_OPEN);
    localparam int CW = $clog2(MAX_OPEN + 1);

    shmm_pkg::back_state_t state_reg, state_next;
    logic [IW-1:0]         i_reg, i_next;
    logic [CW-1:0]         w_reg, w_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [15:0]           lfp_reg, lfp_next;
    logic                  drop_reg, drop_next;
    shmm_pkg::cmd_t        cur_reg, cur_next;
    shmm_pkg::out_word_t   pend_reg, pend_next;
    logic                  pend_valid_reg, pend_valid_next;

    logic [CW-1:0]         i_ext;
    logic                  hit_ok;
    logic                  filter_go;
    logic                  can_emit;
    shmm_pkg::entry_t      upd;
    shmm_pkg::entry_t      fresh;
    shmm_pkg::out_word_t   new_res;

    assign i_ext    = CW'(i_reg) + CW'(1);
    assign can_emit = !pend_valid_reg || !res_full;

    assign hit_ok = (ram_rdata.last_query_start <= cur_reg.query_start)
                 && (17'(cur_reg.query_start) <= ram_rdata.query_end)
                 && (ram_rdata.last_ref_start <= cur_reg.ref_start)
                 && (33'(cur_reg.ref_start) <= ram_rdata.ref_end);

    assign filter_go = 17'(cur_reg.query_start) > (17'(lfp_reg) + 17'(filter_advance));

    always_comb
    begin
        upd                  = ram_rdata;
        upd.last_query_start = cur_reg.query_start;
        upd.last_ref_start   = cur_reg.ref_start;
        if (cur_reg.query_end > ram_rdata.query_end)
        begin
            upd.query_end = cur_reg.query_end;
        end
        if (cur_reg.ref_end > ram_rdata.ref_end)
        begin
            upd.ref_end = cur_reg.ref_end;
        end

        fresh.last_query_start = cur_reg.query_start;
        fresh.last_ref_start   = cur_reg.ref_start;
        fresh.query_start      = cur_reg.query_start;
        fresh.query_end        = cur_reg.query_end;
        fresh.ref_start        = cur_reg.ref_start;
        fresh.ref_end          = cur_reg.ref_end;

        new_res.match_query_start = ram_rdata.query_start;
        new_res.match_query_end   = ram_rdata.query_end;
        new_res.match_ref_start   = ram_rdata.ref_start;
        new_res.match_ref_end     = ram_rdata.ref_end;
        new_res.match_ref_ident   = cur_reg.ref_ident;
        new_res.overflow_seen     = drop_reg;
        new_res.last_of_run       = 1'b0;
    end

    always_comb
    begin
        state_next      = state_reg;
        i_next          = i_reg;
        w_next          = w_reg;
        count_next      = count_reg;
        lfp_next        = lfp_reg;
        drop_next       = drop_reg;
        cur_next        = cur_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        cmd_pop         = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = i_reg;
        ram_wdata       = ram_rdata;
        ram_raddr       = i_reg;
        res_push        = 1'b0;
        res_word        = pend_reg;
        res_word.last_of_run = (state_reg == shmm_pkg::BK_DONE);

        case (state_reg)
            shmm_pkg::BK_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop    = 1'b1;
                    cur_next   = cmd;
                    i_next     = '0;
                    state_next = (count_reg == '0) ? shmm_pkg::BK_ADD : shmm_pkg::BK_ARD;
                end
            end
            shmm_pkg::BK_ARD:
            begin
                state_next = shmm_pkg::BK_ACHK;
            end
            shmm_pkg::BK_ACHK:
            begin
                if (hit_ok)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = upd;
                    state_next = shmm_pkg::BK_FSTART;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = (i_ext == count_reg) ? shmm_pkg::BK_ADD : shmm_pkg::BK_ARD;
                end
            end
            shmm_pkg::BK_ADD:
            begin
                if (count_reg < CW'(MAX_OPEN))
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = count_reg[IW-1:0];
                    ram_wdata  = fresh;
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    drop_next = 1'b1;
                end
                state_next = shmm_pkg::BK_FSTART;
            end
            shmm_pkg::BK_FSTART:
            begin
                i_next = '0;
                w_next = '0;
                if (filter_go)
                begin
                    lfp_next   = cur_reg.query_start;
                    state_next = (count_reg == '0) ? shmm_pkg::BK_GSTART : shmm_pkg::BK_FRD;
                end
                else
                begin
                    state_next = shmm_pkg::BK_GSTART;
                end
            end
            shmm_pkg::BK_FRD:
            begin
                state_next = shmm_pkg::BK_FCHK;
            end
            shmm_pkg::BK_FCHK:
            begin
                if (ram_rdata.query_end < 17'(cur_reg.query_start))
                begin
                    if (can_emit)
                    begin
                        res_push        = pend_valid_reg;
                        pend_next       = new_res;
                        pend_valid_next = 1'b1;
                        i_next          = i_reg + 1'b1;
                        if (i_ext == count_reg)
                        begin
                            count_next = w_reg;
                            state_next = shmm_pkg::BK_GSTART;
                        end
                        else
                        begin
                            state_next = shmm_pkg::BK_FRD;
                        end
                    end
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = w_reg[IW-1:0];
                    w_next    = w_reg + 1'b1;
                    i_next    = i_reg + 1'b1;
                    if (i_ext == count_reg)
                    begin
                        count_next = w_reg + 1'b1;
                        state_next = shmm_pkg::BK_GSTART;
                    end
                    else
                    begin
                        state_next = shmm_pkg::BK_FRD;
                    end
                end
            end
            shmm_pkg::BK_GSTART:
            begin
                i_next = '0;
                if (cur_reg.group_end)
                begin
                    if (count_reg == '0)
                    begin
                        lfp_next   = '0;
                        drop_next  = 1'b0;
                        state_next = shmm_pkg::BK_DONE;
                    end
                    else
                    begin
                        state_next = shmm_pkg::BK_GRD;
                    end
                end
                else
                begin
                    state_next = shmm_pkg::BK_DONE;
                end
            end
            shmm_pkg::BK_GRD:
            begin
                state_next = shmm_pkg::BK_GCHK;
            end
            shmm_pkg::BK_GCHK:
            begin
                if (can_emit)
                begin
                    res_push        = pend_valid_reg;
                    pend_next       = new_res;
                    pend_valid_next = 1'b1;
                    i_next          = i_reg + 1'b1;
                    if (i_ext == count_reg)
                    begin
                        count_next = '0;
                        lfp_next   = '0;
                        drop_next  = 1'b0;
                        state_next = shmm_pkg::BK_DONE;
                    end
                    else
                    begin
                        state_next = shmm_pkg::BK_GRD;
                    end
                end
            end
            shmm_pkg::BK_DONE:
            begin
                if (can_emit)
                begin
                    res_push        = pend_valid_reg;
                    pend_valid_next = 1'b0;
                    state_next      = shmm_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = shmm_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= shmm_pkg::BK_IDLE;
            i_reg          <= '0;
            w_reg          <= '0;
            count_reg      <= '0;
            lfp_reg        <= '0;
            drop_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            i_reg          <= i_next;
            w_reg          <= w_next;
            count_reg      <= count_next;
            lfp_reg        <= lfp_next;
            drop_reg       <= drop_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        pend_reg <= pend_next;
    end

endmodule

`default_nettype wire

// ===== rtl/seed_hit_match_merger.sv =====
// ----------------------------------------------------------------------------
// seed_hit_match_merger
// Merges seed hits of a reference group into maximal matches.
// ----------------------------------------------------------------------------
// channel   direction  handshake              word
// hit       in         push / full            shmm_pkg::in_word_t
// match     out        pop / empty            shmm_pkg::out_word_t
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A hit passes through the back end states in turn; each list entry visited in the
// extend scan, the filter pass and the group flush takes a read and a check, set
// by the single read port of the match RAM.
// Reset clears the list count at once; no clearing pass.
// A full result queue stalls the back end; the hit queue keeps taking words until full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module seed_hit_match_merger #(
    parameter int MAX_OPEN = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  push,
    output logic                                       full,
    input  wire shmm_pkg::in_word_t                    hit,
    output logic                                       empty,
    input  wire logic                                  pop,
    output shmm_pkg::out_word_t                        match,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [shmm_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [shmm_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int IW = $clog2(MAX_OPEN);

    logic [15:0]         span_length_reg;
    logic [5:0]          filter_advance_reg;
    shmm_pkg::cmd_t      cmd;
    logic                cmd_empty;
    logic                cmd_pop;
    logic                ram_we;
    logic [IW-1:0]       ram_waddr;
    logic [IW-1:0]       ram_raddr;
    shmm_pkg::entry_t    ram_wdata;
    shmm_pkg::entry_t    ram_rdata;
    logic [$bits(shmm_pkg::entry_t)-1:0] ram_rbits;
    logic                res_push;
    logic                res_full;
    shmm_pkg::out_word_t res_word;
    logic [$bits(shmm_pkg::out_word_t)-1:0] match_bits;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_length_reg    <= shmm_pkg::SPAN_LENGTH_RESET;
            filter_advance_reg <= shmm_pkg::FILTER_ADVANCE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == shmm_pkg::CFG_SPAN_LENGTH)
            begin
                span_length_reg <= cfg_data;
            end
            else if (cfg_index == shmm_pkg::CFG_FILTER_ADVANCE)
            begin
                filter_advance_reg <= cfg_data[5:0];
            end
        end
    end

    shmm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .hit         (hit),
        .span_length (span_length_reg),
        .cmd_pop     (cmd_pop),
        .cmd_empty   (cmd_empty),
        .cmd         (cmd)
    );

    shmm_ram #(
        .WIDTH($bits(shmm_pkg::entry_t)),
        .DEPTH(MAX_OPEN)
    ) u_list (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rbits)
    );

    assign ram_rdata = shmm_pkg::entry_t'(ram_rbits);

    shmm_back #(
        .MAX_OPEN(MAX_OPEN)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cmd_empty      (cmd_empty),
        .cmd_pop        (cmd_pop),
        .filter_advance (filter_advance_reg),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .ram_raddr      (ram_raddr),
        .ram_rdata      (ram_rdata),
        .res_push       (res_push),
        .res_word       (res_word),
        .res_full       (res_full)
    );

    shmm_fifo #(
        .WIDTH($bits(shmm_pkg::out_word_t)),
        .DEPTH(2)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_word),
        .full  (res_full),
        .pop   (pop),
        .rdata (match_bits),
        .empty (empty)
    );

    assign match = shmm_pkg::out_word_t'(match_bits);

endmodule

`default_nettype wire

// ===== rtl/shmm_checker.sv =====
// ----------------------------------------------------------------------------
// shmm_checker
// Port-level checks of the match merger, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module shmm_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             push,
    input  wire logic                             full,
    input  wire shmm_pkg::in_word_t               hit,
    input  wire logic                             empty,
    input  wire logic                             pop,
    input  wire shmm_pkg::out_word_t              match,
    input  wire logic                             cfg_valid,
    input  wire logic                             cfg_ready,
    input  wire logic [shmm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [shmm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(match)))
        else $error("waiting result word changed");

    a_query_order: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (match.match_query_end >= 17'(match.match_query_start)))
        else $error("match query end below its start");

    a_ref_order: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (match.match_ref_end >= 33'(match.match_ref_start)))
        else $error("match reference end below its start");

endmodule

bind seed_hit_match_merger shmm_checker u_shmm_checker (.*);

`default_nettype wire
